// ===== rtl/crc8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8d_pkg
// Shared types, constants and CRC-8 helpers of the reply frame deframer.
// ----------------------------------------------------------------------------
package crc8d_pkg;

   // Frame geometry: seven held bytes plus the incoming CRC byte
   localparam int FRAME_BYTES = 8;
   localparam int WIN_BYTES   = FRAME_BYTES - 1;
   localparam int FILL_BITS   = $clog2(FRAME_BYTES);
   localparam int CRC_ZERO_PAD = WIN_BYTES - 1;

   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WIN_BYTES);

   // CRC-8, polynomial 0x07, MSB first
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // Configuration registers
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_MARKER = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STATUS_ID    = 8'd1;

   localparam logic [7:0] START_MARKER_RESET = 8'hAB;
   localparam logic [7:0] STATUS_ID_RESET    = 8'h10;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [7:0]         response_id;
      logic               is_status;
      logic signed [15:0] speed_value;
      logic signed [15:0] torque_value;
      logic               running_flag;
   } result_type;

   // Advance the CRC register by one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc_in, input logic [7:0] data);
      logic [7:0] acc;
      acc = acc_in ^ data;
      for (int b = 0; b < 8; b++) begin
         if ((acc & CRC_TOP) != 8'h00) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

   // CRC contribution of a leading byte followed by the rest of the held bytes
   // as zeros; XOR it out to remove that byte from a running CRC
   function automatic logic [7:0] crc8_lead(input logic [7:0] lead);
      logic [7:0] acc;
      acc = crc8_byte(8'h00, lead);
      for (int i = 0; i < CRC_ZERO_PAD; i++) begin
         acc = crc8_byte(acc, 8'h00);
      end
      return acc;
   endfunction

endpackage

// ===== rtl/crc8d_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8d_ifs
// Valid/ready channels of the reply frame deframer: bytes, results, CSR writes.
// ----------------------------------------------------------------------------

interface crc8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8d_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         response_id;
   logic               is_status;
   logic signed [15:0] speed_value;
   logic signed [15:0] torque_value;
   logic               running_flag;

   modport source (output valid, output response_id, output is_status,
                   output speed_value, output torque_value, output running_flag,
                   input ready);
   modport sink   (input valid, input response_id, input is_status,
                   input speed_value, input torque_value, input running_flag,
                   output ready);
endinterface

interface crc8d_csr_if;
   import crc8d_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [7:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crc8d_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8d_window
// Sliding byte window with running CRC-8; checks each full frame in one step.
// ----------------------------------------------------------------------------
module crc8d_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  crc8d_pkg::byte_type  rx_byte,
   input  crc8d_pkg::byte_type  start_marker,
   input  crc8d_pkg::byte_type  status_id,
   output logic                 hit,
   output crc8d_pkg::result_type result
);
   import crc8d_pkg::*;

   byte_type             win_ff [WIN_BYTES];
   byte_type             win_in [WIN_BYTES];
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [7:0]           crc_ff;
   logic [7:0]           crc_in;
   logic                 full;

   // Check the frame: held bytes plus the incoming byte as its CRC
   assign full = (fill_ff == FILL_FULL);
   assign hit  = full && (win_ff[0] == start_marker) && (crc_ff == rx_byte);

   // Decode the fields of a passing frame
   always_comb begin
      result.response_id  = win_ff[1];
      result.is_status    = (win_ff[1] == status_id);
      result.speed_value  = {win_ff[2], win_ff[3]};
      result.torque_value = {win_ff[4], win_ff[5]};
      result.running_flag = (win_ff[6] != 8'h00);
   end

   // Next window state: fill, clear on a good frame, or slide on a bad one
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      crc_in  = crc_ff;
      if (!full) begin
         win_in[fill_ff] = rx_byte;
         fill_in         = fill_ff + 1'b1;
         crc_in          = crc8_byte(crc_ff, rx_byte);
      end else if (hit) begin
         fill_in = '0;
         crc_in  = 8'h00;
      end else begin
         for (int i = 0; i < WIN_BYTES - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_BYTES-1] = rx_byte;
         crc_in = crc8_byte(crc_ff ^ crc8_lead(win_ff[0]), rx_byte);
      end
   end

   // Hold window bytes (payload, no reset)
   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_in;
      end
   end

   // Advance fill count and running CRC
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         crc_ff  <= 8'h00;
      end else if (step) begin
         fill_ff <= fill_in;
         crc_ff  <= crc_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_hit : assert property (@(posedge clock) disable iff (reset)
      step && hit |=> fill_ff == '0 && crc_ff == 8'h00)
      else $error("window not cleared after good frame");

   a_stay_full_on_drop : assert property (@(posedge clock) disable iff (reset)
      step && full && !hit |=> full)
      else $error("window left full state after dropped byte");

   a_hold_when_idle : assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(fill_ff) && $stable(crc_ff))
      else $error("window state changed without a step");

   a_hit_needs_full : assert property (@(posedge clock) disable iff (reset)
      hit |-> fill_ff == FILL_FULL)
      else $error("frame hit with partial window");

   a_empty_crc_zero : assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> crc_ff == 8'h00)
      else $error("running CRC nonzero on empty window");
`endif

endmodule

// ===== rtl/crc8_reply_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_reply_frame_deframer
// Finds CRC-8 protected 8-byte reply frames in a byte stream and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received byte per transfer. Bytes slide through a
//   7-byte window; when a start byte and a matching CRC-8 (poly 0x07, init 0)
//   line up, rsp_chan delivers one decoded frame and the window empties.
//   Bytes that do not complete a good frame produce no transfer on rsp_chan.
//   csr_chan writes start_marker (index 0) and status_response_id (index 1);
//   other indexes are ignored. Write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while rsp_chan takes its results. A byte
//   waits in the input register and is checked against the running CRC when
//   it steps, which also loads a good frame's result into the output register.
// Reset:
//   Empties the window, clears both stages and loads 0xAB and 0x10 into the
//   registers.
// Stall:
//   While rsp_chan holds an untaken result, the input register holds its byte
//   and req_chan.ready drops once that register is occupied.
// ----------------------------------------------------------------------------
module crc8_reply_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   crc8d_req_if.sink   req_chan,
   crc8d_rsp_if.source rsp_chan,
   crc8d_csr_if.sink   csr_chan
);
   import crc8d_pkg::*;

   byte_type   rx_ff;
   logic       rx_valid_ff;
   byte_type   start_marker_ff;
   byte_type   status_id_ff;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       step;
   logic       hit;
   result_type result;

   // Process a held byte when the output register can take a result
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = rx_valid_ff && out_free;
   assign req_chan.ready = !rx_valid_ff || step;
   assign csr_chan.ready = 1'b1;

   // Capture configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         status_id_ff    <= STATUS_ID_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_START_MARKER: start_marker_ff <= csr_chan.data;
            CSR_STATUS_ID:    status_id_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Input register: hold one byte transfer
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         rx_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         rx_valid_ff <= 1'b1;
      end else if (step) begin
         rx_valid_ff <= 1'b0;
      end
   end

   crc8d_window u_window (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (rx_ff),
      .start_marker (start_marker_ff),
      .status_id    (status_id_ff),
      .hit          (hit),
      .result       (result)
   );

   // Output register: load a decoded frame, drop it once transferred
   always_ff @(posedge clock) begin
      if (step && hit) begin
         result_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.response_id  = result_ff.response_id;
   assign rsp_chan.is_status    = result_ff.is_status;
   assign rsp_chan.speed_value  = result_ff.speed_value;
   assign rsp_chan.torque_value = result_ff.torque_value;
   assign rsp_chan.running_flag = result_ff.running_flag;

`ifndef SYNTHESIS
   a_hold_result_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(result_ff))
      else $error("pending result lost while stalled");

   a_no_step_when_blocked : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !step)
      else $error("byte processed while output register is blocked");

   a_byte_kept_until_step : assert property (@(posedge clock) disable iff (reset)
      rx_valid_ff && !step |=> rx_valid_ff && $stable(rx_ff))
      else $error("held byte lost before processing");
`endif

endmodule

// ===== tb/crc8_reply_frame_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8d_frame_monitor
// Watches the byte, result and register channels of the reply frame
// deframer. It keeps its own sliding byte window and CRC-8, predicts every
// decoded frame and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module crc8d_frame_monitor (
   input  logic        clock,
   input  logic        reset,
   crc8d_req_if        req_mon,
   crc8d_rsp_if        rsp_mon,
   crc8d_csr_if        csr_mon,
   output int          fail_count,
   output int          pending_count,
   output int          frames_checked,
   output int          status_frames
);
   import crc8d_pkg::*;

   localparam logic [7:0] CRC8_GEN      = 8'h07;

   // Shadow of the block: register copies and the byte window
   logic [7:0] marker_cfg;
   logic [7:0] status_cfg;
   logic [7:0] frame_win [FRAME_BYTES];
   int         win_fill;

   // Decoded frames still owed by the block, oldest first
   result_type pending_frames[$];

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      frames_checked = 0;
      status_frames  = 0;
   end

   // CRC-8 over the seven leading bytes of the window, MSB first, init zero
   function automatic logic [7:0] window_crc();
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         acc = acc ^ frame_win[i];
         for (int k = 0; k < 8; k++) begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ CRC8_GEN) : {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   // Slide one byte into the window; queue a decoded frame when one lines up
   task automatic slide_in_byte(input logic [7:0] rx);
      result_type decoded;
      if (win_fill >= FRAME_BYTES) begin
         win_fill = FRAME_BYTES - 1;
      end
      frame_win[win_fill] = rx;
      win_fill++;
      if (win_fill == FRAME_BYTES) begin
         if (frame_win[0] == marker_cfg && window_crc() == frame_win[FRAME_BYTES - 1]) begin
            decoded.response_id  = frame_win[1];
            decoded.is_status    = (frame_win[1] == status_cfg);
            decoded.speed_value  = {frame_win[2], frame_win[3]};
            decoded.torque_value = {frame_win[4], frame_win[5]};
            decoded.running_flag = (frame_win[6] != 8'h00);
            pending_frames.insert(pending_frames.size(), decoded);
            foreach (frame_win[i]) frame_win[i] = 8'h00;
            win_fill = 0;
         end else begin
            // drop the oldest byte and keep sliding
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
               frame_win[i] = frame_win[i + 1];
            end
            frame_win[FRAME_BYTES - 1] = 8'h00;
            win_fill = FRAME_BYTES - 1;
         end
      end
   endtask

   // Compare one result transfer with the oldest predicted frame
   task automatic check_frame();
      result_type want;
      if (pending_frames.size() == 0) begin
         report_mismatch("unexpected result, response_id", rsp_mon.response_id, 0);
      end else begin
         want = pending_frames.pop_front();
         frames_checked++;
         if (want.is_status) status_frames++;
         if (rsp_mon.response_id !== want.response_id)
            report_mismatch("response_id", rsp_mon.response_id, want.response_id);
         if (rsp_mon.is_status !== want.is_status)
            report_mismatch("is_status", rsp_mon.is_status, want.is_status);
         if (rsp_mon.speed_value !== want.speed_value)
            report_mismatch("speed_value", 16'(rsp_mon.speed_value), 16'(want.speed_value));
         if (rsp_mon.torque_value !== want.torque_value)
            report_mismatch("torque_value", 16'(rsp_mon.torque_value),
                            16'(want.torque_value));
         if (rsp_mon.running_flag !== want.running_flag)
            report_mismatch("running_flag", rsp_mon.running_flag, want.running_flag);
      end
   endtask

   // Sample every transfer at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         marker_cfg = START_MARKER_RESET;
         status_cfg = STATUS_ID_RESET;
         foreach (frame_win[i]) frame_win[i] = 8'h00;
         win_fill = 0;
         pending_frames.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_START_MARKER) begin
               marker_cfg = csr_mon.data;
            end else if (csr_mon.index == CSR_STATUS_ID) begin
               status_cfg = csr_mon.data;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            slide_in_byte(req_mon.rx_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_frame();
         end
      end
      pending_count = pending_frames.size();
   end

endmodule

// ===== tb/crc8_reply_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_reply_frame_deframer_tb
// Drives byte streams of well-formed, corrupted and noise frames into the
// deframer under several register settings, stalls the result side at
// random and twice for a long stretch, and reports the monitor's verdict.
// ----------------------------------------------------------------------------
module crc8_reply_frame_deframer_tb;
   import crc8d_pkg::*;

   localparam int PHASE_BYTES    = 370;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_SETTINGS   = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 8'hFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crc8d_req_if req_chan ();
   crc8d_rsp_if rsp_chan ();
   crc8d_csr_if csr_chan ();

   int fail_count;
   int pending_count;
   int frames_checked;
   int status_frames;

   int         bytes_sent;
   int         send_calm_left;
   int         rsp_calm_left;
   int         quiet_cycles;
   logic [7:0] cur_marker;
   logic [7:0] cur_status;

   logic [7:0] marker_set [NUM_SETTINGS];
   logic [7:0] status_set [NUM_SETTINGS];

   crc8_reply_frame_deframer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   crc8d_frame_monitor u_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .frames_checked (frames_checked),
      .status_frames  (status_frames)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Random wait length, with occasional stretches of no waiting
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 60);
      end
      return $urandom_range(0, 14);
   endfunction

   // Mostly random words, sometimes one of the extremes
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one byte and hold it until the transfer
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = draw_wait(send_calm_left);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] marker, input logic [7:0] id,
                             input logic [15:0] speed, input logic [15:0] torque,
                             input logic [7:0] run, input bit corrupt);
      logic [7:0] fb [FRAME_BYTES];
      logic [7:0] acc;
      int         pos;
      fb = '{marker, id, speed[15:8], speed[7:0], torque[15:8], torque[7:0], run, 8'h00};
      acc = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         acc = crc8_byte(acc, fb[i]);
      end
      fb[FRAME_BYTES - 1] = acc;
      // flip one bit anywhere, start byte and CRC byte included
      if (corrupt) begin
         pos = $urandom_range(0, FRAME_BYTES - 1);
         fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_byte(fb[i]);
      end
   endtask

   task automatic send_random_frame(input bit corrupt);
      logic [7:0] id;
      logic [7:0] run;
      id  = ($urandom_range(0, 2) == 0) ? cur_status : 8'($urandom);
      run = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      send_frame(cur_marker, id, pick_word(), pick_word(), run, corrupt);
   endtask

   task automatic req_idle();
      req_chan.valid <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index, input logic [7:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      @(negedge clock);
   endtask

   // Wait for every predicted frame, then let a held byte clear the block
   task automatic wait_drained(input int settle);
      do @(negedge clock); while (pending_count != 0);
      repeat (settle) @(negedge clock);
   endtask

   // Stimulus
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_START_MARKER;
      csr_chan.data    = 8'h00;
      bytes_sent       = 0;
      send_calm_left   = 0;
      cur_marker       = START_MARKER_RESET;
      cur_status       = STATUS_ID_RESET;

      marker_set = '{8'h00, 8'hFF, 8'($urandom), START_MARKER_RESET};
      status_set = '{8'hFF, 8'h00, 8'($urandom), STATUS_ID_RESET};

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: status frame at the extremes, a bad CRC, a stray byte,
      // then a non-status frame that has to slide in past the leftovers
      send_frame(cur_marker, cur_status, 16'h7FFF, 16'h8000, 8'h01, 1'b0);
      send_frame(cur_marker, cur_status, 16'h1234, 16'h5678, 8'hFF, 1'b1);
      send_byte(8'hAB);
      send_frame(cur_marker, 8'h55, 16'h8000, 16'h7FFF, 8'h00, 1'b0);
      req_idle();

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         wait_drained(SETTLE_CYCLES);
         // an index past the register list must leave both untouched
         csr_write(CSR_UNUSED_INDEX, 8'($urandom));
         csr_write(CSR_START_MARKER, marker_set[p]);
         csr_write(CSR_STATUS_ID, status_set[p]);
         csr_chan.valid <= 1'b0;
         cur_marker = marker_set[p];
         cur_status = status_set[p];

         // Mostly clean frames, some corrupted, some raw noise
         for (int n = bytes_sent + PHASE_BYTES; bytes_sent < n; ) begin
            case ($urandom_range(0, 19))
               0, 1, 2:  send_random_frame(1'b1);
               3, 4, 5: begin
                  repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
               end
               default:  send_random_frame(1'b0);
            endcase
         end
         req_idle();
      end

      wait_drained(DRAIN_CYCLES);
      $display("Sent %0d bytes across %0d register settings plus reset values;",
               bytes_sent, NUM_SETTINGS);
      $display("decoded %0d frames, %0d flagged as status.", frames_checked, status_frames);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Result side: random stalls, two long hold-offs to back up the input
   initial begin : rsp_side
      int stall;
      int taken;
      taken          = 0;
      rsp_calm_left  = 0;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (taken == 25 || taken == 90) begin
            stall = LONG_HOLD;
         end else begin
            stall = draw_wait(rsp_calm_left);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
         taken++;
      end
   end

   // Watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
